// ----- rtl/core/irdist_pkg.sv -----
// ----------------------------------------------------------------------------
// irdist_pkg
// Shared widths, defaults and the fixed sensor breakpoint and distance tables
// for the infrared range linearizer.
// ----------------------------------------------------------------------------
package irdist_pkg;

  localparam int SAMPLE_W   = 12;  // converter reading, also breakpoint width
  localparam int CM_W       = 10;  // table distance in whole centimeters
  localparam int DIST_W     = 15;  // distance result, fixed point
  localparam int SEG_W      = 4;   // segment index result
  localparam int STEP_W     = 4;   // per-segment step register
  localparam int SLOT_W     = 5;   // index into the 32 table slots
  localparam int TABLE_SLOTS = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = 4'd5;

  localparam int TABLE_ENTRIES = 15;
  localparam int FRACTION_BITS = 8;

  // Descending converter breakpoints; unused slots read as zero.
  function automatic logic [SAMPLE_W-1:0] bp_at(input logic [SLOT_W-1:0] idx);
    logic [SAMPLE_W-1:0] v;
    case (idx)
      5'd0:    v = 12'd4095;
      5'd1:    v = 12'd3050;
      5'd2:    v = 12'd1980;
      5'd3:    v = 12'd1370;
      5'd4:    v = 12'd950;
      5'd5:    v = 12'd830;
      5'd6:    v = 12'd730;
      5'd7:    v = 12'd650;
      5'd8:    v = 12'd570;
      5'd9:    v = 12'd530;
      5'd10:   v = 12'd460;
      5'd11:   v = 12'd390;
      5'd12:   v = 12'd330;
      5'd13:   v = 12'd300;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Distance at each breakpoint in centimeters; unused slots read as zero.
  function automatic logic [CM_W-1:0] cm_at(input logic [SLOT_W-1:0] idx);
    logic [CM_W-1:0] v;
    case (idx)
      5'd0:    v = 10'd0;
      5'd1:    v = 10'd10;
      5'd2:    v = 10'd15;
      5'd3:    v = 10'd20;
      5'd4:    v = 10'd25;
      5'd5:    v = 10'd30;
      5'd6:    v = 10'd35;
      5'd7:    v = 10'd40;
      5'd8:    v = 10'd45;
      5'd9:    v = 10'd50;
      5'd10:   v = 10'd55;
      5'd11:   v = 10'd60;
      5'd12:   v = 10'd65;
      5'd13:   v = 10'd70;
      5'd14:   v = 10'd999;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/irdist_div.sv -----
// ----------------------------------------------------------------------------
// irdist_div
// Pipelined restoring divider for the segment fraction: one quotient bit per
// stage, numerator never above the divisor, elastic valid/ready per stage.
// ----------------------------------------------------------------------------
module irdist_div #(
  parameter int QBITS = irdist_pkg::FRACTION_BITS + 1,
  parameter int TAG_W = irdist_pkg::SEG_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [irdist_pkg::SAMPLE_W-1:0] in_num,
  input  logic [irdist_pkg::SAMPLE_W-1:0] in_den,
  input  logic [TAG_W-1:0]              in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [QBITS-1:0]              out_quot,
  output logic [TAG_W-1:0]              out_tag
);

  localparam int VAL_W = irdist_pkg::SAMPLE_W;

  logic [QBITS-1:0] vld;
  logic [QBITS-1:0] rdy;
  logic [VAL_W-1:0] rem  [QBITS];
  logic [VAL_W-1:0] den  [QBITS];
  logic [QBITS-1:0] quot [QBITS];
  logic [TAG_W-1:0] tag  [QBITS];

  for (genvar j = 0; j < QBITS; j++) begin : g_stage
    logic             vin;
    logic [VAL_W-1:0] din;
    logic [QBITS-1:0] qin;
    logic [TAG_W-1:0] tin;
    logic [VAL_W:0]   trial;
    logic             hit;

    if (j == 0) begin : g_first
      assign vin   = in_valid;
      assign din   = in_den;
      assign qin   = '0;
      assign tin   = in_tag;
      assign trial = {1'b0, in_num};
    end else begin : g_next
      assign vin   = vld[j-1];
      assign din   = den[j-1];
      assign qin   = quot[j-1];
      assign tin   = tag[j-1];
      // remainder stays below the divisor, so the doubled value fits
      assign trial = {rem[j-1], 1'b0};
    end

    if (j == QBITS - 1) begin : g_last_rdy
      assign rdy[j] = ~vld[j] | out_ready;
    end else begin : g_mid_rdy
      assign rdy[j] = ~vld[j] | rdy[j+1];
    end

    assign hit = (trial >= {1'b0, din});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j] && vin) begin
        rem[j]  <= hit ? VAL_W'(trial - {1'b0, din}) : trial[VAL_W-1:0];
        den[j]  <= din;
        quot[j] <= {qin[QBITS-2:0], hit};
        tag[j]  <= tin;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[QBITS-1];
  assign out_quot  = quot[QBITS-1];
  assign out_tag   = tag[QBITS-1];

endmodule

// ----- rtl/core/ir_adc_to_distance_interp.sv -----
// ----------------------------------------------------------------------------
// ir_adc_to_distance_interp
// Infrared range-sensor linearizer: piecewise linear lookup from a 12-bit
// converter reading to a distance in centimeters with fraction bits.
// ----------------------------------------------------------------------------
// One word is taken per cycle while the output is not stalled. Each word passes
// through the registered stages in order: the breakpoint search, the segment
// span, the bit-per-stage fraction divider, and the scale and add into the
// output register. Every stage has its own valid bit and fills bubbles, so a
// stalled output holds every result while the stages upstream keep taking
// words until the pipeline is full.
// segment_step_cm may only be changed while no word is in flight.
module ir_adc_to_distance_interp #(
  parameter int TABLE_ENTRIES = irdist_pkg::TABLE_ENTRIES,
  parameter int FRACTION_BITS = irdist_pkg::FRACTION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,     // segment_step_cm
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // [11:0] adc_sample, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata        // [14:0] distance_q8, [18:15] segment_index,
                                     // [23:19] zero
);

  localparam int SAMPLE_W = irdist_pkg::SAMPLE_W;
  localparam int SLOT_W   = irdist_pkg::SLOT_W;
  localparam int LAST_SEG = TABLE_ENTRIES - 2;
  localparam int K_W      = (TABLE_ENTRIES - 1 > 1) ? $clog2(TABLE_ENTRIES - 1) : 1;
  localparam int QBITS    = FRACTION_BITS + 1;
  localparam int SUM_W    = irdist_pkg::CM_W + FRACTION_BITS + 1;
  localparam int PROD_W   = QBITS + irdist_pkg::STEP_W;

  // configuration
  logic [irdist_pkg::STEP_W-1:0] segment_step_cm;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_step_cm <= irdist_pkg::STEP_RESET;
    end else if (cfg_we) begin
      segment_step_cm <= cfg_wdata;
    end
  end

  // stage A: breakpoint search
  logic                a_vld;
  logic                a_rdy;
  logic [SAMPLE_W-1:0] a_sample;
  logic [K_W-1:0]      a_k;
  logic [SAMPLE_W-1:0] in_sample;
  logic [K_W-1:0]      k_sel;

  // stage B: segment span
  logic                b_vld;
  logic                b_rdy;
  logic [SAMPLE_W-1:0] b_num;
  logic [SAMPLE_W-1:0] b_den;
  logic [K_W-1:0]      b_k;
  logic [SAMPLE_W-1:0] bp_hi;
  logic [SAMPLE_W-1:0] bp_lo;
  logic [SAMPLE_W-1:0] num_raw;
  logic [SAMPLE_W-1:0] span;
  logic                seg_ok;

  // divider
  logic                div_in_ready;
  logic                div_out_valid;
  logic [QBITS-1:0]    div_quot;
  logic [K_W-1:0]      div_k;

  // stage C: output register
  logic                c_vld;
  logic                c_rdy;
  logic [irdist_pkg::DIST_W-1:0] c_dist;
  logic [irdist_pkg::SEG_W-1:0]  c_seg;
  logic [SUM_W-1:0]    base_q;
  logic [PROD_W-1:0]   step_q;
  logic [SUM_W-1:0]    dist_sum;

  assign in_sample = s_tdata[SAMPLE_W-1:0];

  // largest segment whose upper breakpoint is at or above the sample
  always_comb begin
    k_sel = '0;
    for (int i = 0; i <= LAST_SEG; i++) begin
      if (irdist_pkg::bp_at(SLOT_W'(i)) >= in_sample) begin
        k_sel = K_W'(i);
      end
    end
  end

  assign a_rdy    = ~a_vld | b_rdy;
  assign s_tready = a_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_rdy) begin
      a_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && s_tvalid) begin
      a_sample <= in_sample;
      a_k      <= k_sel;
    end
  end

  assign bp_hi   = irdist_pkg::bp_at(SLOT_W'(a_k));
  assign bp_lo   = irdist_pkg::bp_at(SLOT_W'(a_k) + SLOT_W'(1));
  assign num_raw = bp_hi - a_sample;
  assign span    = bp_hi - bp_lo;
  assign seg_ok  = (bp_hi >= a_sample) && (bp_hi > bp_lo);

  assign b_rdy = ~b_vld | div_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_rdy) begin
      b_vld <= a_vld;
    end
  end

  // flat or unreachable segment: force a zero fraction with a unit divisor
  always_ff @(posedge clk) begin
    if (b_rdy && a_vld) begin
      b_k <= a_k;
      if (seg_ok) begin
        b_num <= (num_raw > span) ? span : num_raw;
        b_den <= span;
      end else begin
        b_num <= '0;
        b_den <= SAMPLE_W'(1);
      end
    end
  end

  irdist_div #(
    .QBITS (QBITS),
    .TAG_W (K_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_vld),
    .in_ready  (div_in_ready),
    .in_num    (b_num),
    .in_den    (b_den),
    .in_tag    (b_k),
    .out_valid (div_out_valid),
    .out_ready (c_rdy),
    .out_quot  (div_quot),
    .out_tag   (div_k)
  );

  assign base_q   = SUM_W'(irdist_pkg::cm_at(SLOT_W'(div_k))) << FRACTION_BITS;
  assign step_q   = PROD_W'(div_quot) * PROD_W'(segment_step_cm);
  assign dist_sum = base_q + SUM_W'(step_q);

  assign c_rdy = ~c_vld | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (c_rdy) begin
      c_vld <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && div_out_valid) begin
      c_dist <= dist_sum[irdist_pkg::DIST_W-1:0];
      c_seg  <= irdist_pkg::SEG_W'(div_k);
    end
  end

  assign m_tvalid = c_vld;
  assign m_tdata  = {5'd0, c_seg, c_dist};

endmodule
